// ===== src/ltws_pkg.sv =====
// ltws_pkg: shared constants, types and command codes for the loop timing statistics block
// no dependencies
`timescale 1ns / 1ps

package ltws_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = SAMPLE_BITS + IDX_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS + IDX_W + 1;
    localparam int VAR_W       = 48;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    typedef struct packed {
        logic                   series;
        logic [CNT_W-1:0]       count;
        logic [SAMPLE_BITS-1:0] last;
        logic [SAMPLE_BITS-1:0] mean;
        logic [VAR_W-1:0]       var_v;
        logic [SAMPLE_BITS-1:0] min_v;
        logic [SAMPLE_BITS-1:0] max_v;
    } t_result;

    // divider request from the sequencer
    typedef struct packed {
        logic             start;
        logic [SQ_W+IDX_W+1:0] num;
        logic [2*CNT_W-1:0]    den;
    } t_div_req;

endpackage

// ===== src/ltws_div.sv =====
// ltws_div: restoring serial divider, one quotient bit per cycle
// depends on ltws_pkg
`timescale 1ns / 1ps

module ltws_div
    import ltws_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    output logic                    o_done,
    output logic [SQ_W+IDX_W+1:0]   o_quot
);

    localparam int NW = SQ_W + IDX_W + 2;
    localparam int DW = 2 * CNT_W;
    localparam int BW = $clog2(NW + 1);

    logic [NW-1:0] r_quot, n_quot;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [BW-1:0] r_bits;
    logic          r_busy, r_done;
    logic [DW:0]   w_shift;

    always_comb begin
        w_shift = {r_rem[DW-1:0], r_quot[NW-1]};
        n_quot  = {r_quot[NW-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_den}) begin
            n_rem     = w_shift - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bits <= BW'(NW);
                r_quot <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_bits <= r_bits - 1'b1;
                if (r_bits == BW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/ltws_seq.sv =====
// ltws_seq: ring memories, window walk and statistics sequencer
// depends on ltws_pkg and ltws_div
`timescale 1ns / 1ps

module ltws_seq
    import ltws_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [1:0]             i_cmd,
    input  logic [31:0]            i_now,
    input  logic [CNT_W-1:0]       i_win,
    input  logic                   i_cfg_we,
    output logic                   o_busy,
    output logic                   o_done,
    output t_result                o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_DIVM = 3'd4;
    localparam logic [2:0] S_DIVV = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int NW = SQ_W + IDX_W + 2;

    logic [2:0]             r_state;
    logic [31:0]            r_ref;
    logic [SAMPLE_BITS-1:0] r_ring_p [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_ring_d [MAX_WINDOW];
    logic [IDX_W-1:0]       r_head [2];
    logic [CNT_W-1:0]       r_cnt [2];
    logic                   r_sel;
    logic [IDX_W-1:0]       r_addr;
    logic [CNT_W-1:0]       r_left;
    logic                   r_rvalid;
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sumsq;
    logic [2*SUM_W-1:0]     r_prod;
    logic                   r_pstep;
    t_result                r_res;
    t_div_req               w_req;
    logic                   w_ddone;
    logic [NW-1:0]          w_quot;
    logic [CNT_W-1:0]       w_eff;
    logic [SAMPLE_BITS-1:0] w_delta;
    logic [31:0]            w_diff;

    always_comb begin
        if (i_win == '0)
            w_eff = CNT_W'(1);
        else if (i_win > CNT_W'(MAX_WINDOW))
            w_eff = CNT_W'(MAX_WINDOW);
        else
            w_eff = i_win;
        w_diff  = i_now - r_ref;
        w_delta = (w_diff > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : w_diff[SAMPLE_BITS-1:0];
    end

    ltws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_req       = '0;
        w_req.den   = {{CNT_W{1'b0}}, r_res.count};
        if (r_state == S_ACC && r_left == '0 && !r_rvalid && r_res.count != '0) begin
            w_req.start = 1'b1;
            w_req.num   = NW'(r_sum);
        end else if (r_state == S_SQ && r_pstep) begin
            w_req.start = 1'b1;
            w_req.num   = NW'(r_prod);
            w_req.den   = (2*CNT_W)'(r_res.count) * (2*CNT_W)'(r_res.count);
        end
    end

    // ring writes and registered ring read
    always_ff @(posedge i_clk) begin
        if (i_go && i_cmd == CMD_START)
            r_ring_p[r_head[0]] <= w_delta;
        if (i_go && i_cmd == CMD_STOP)
            r_ring_d[r_head[1]] <= w_delta;
        r_rdata <= r_sel ? r_ring_d[r_addr] : r_ring_p[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ref    <= '0;
            r_head   <= '{default: '0};
            r_cnt    <= '{default: '0};
            r_rvalid <= 1'b0;
            r_pstep  <= 1'b0;
            r_left   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (r_cnt[0] > w_eff) r_cnt[0] <= w_eff;
                if (r_cnt[1] > w_eff) r_cnt[1] <= w_eff;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        logic [CNT_W-1:0] v_c;
                        logic             v_s;
                        t_result          v_res;
                        v_s = (i_cmd == CMD_STOP);
                        v_c = r_cnt[v_s];
                        if (i_cmd == CMD_CLEAR) begin
                            r_cnt[0] <= '0;
                            r_cnt[1] <= '0;
                            v_c = '0;
                        end else begin
                            if (v_c < CNT_W'(MAX_WINDOW)) v_c = v_c + 1'b1;
                            if (v_c > w_eff) v_c = w_eff;
                            r_cnt[v_s]  <= v_c;
                            r_head[v_s] <= r_head[v_s] + 1'b1;
                            if (i_cmd == CMD_START) r_ref <= i_now;
                        end
                        v_res          = '0;
                        v_res.series   = v_s;
                        v_res.count    = v_c;
                        v_res.min_v    = (v_c == '0) ? '0 : SAMPLE_MAX;
                        r_sel          <= v_s;
                        r_addr         <= r_head[v_s] + 1'b1 - IDX_W'(v_c);
                        r_left         <= v_c;
                        r_res          <= v_res;
                        r_sum          <= '0;
                        r_sumsq        <= '0;
                        r_state        <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // one address issued, one sample folded in per cycle
                    r_rvalid <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_rvalid) begin
                        r_sum      <= r_sum + SUM_W'(r_rdata);
                        r_prod     <= (2*SUM_W)'(r_rdata) * (2*SUM_W)'(r_rdata);
                        r_pstep    <= 1'b1;
                        r_res.last <= r_rdata;
                        if (r_rdata < r_res.min_v) r_res.min_v <= r_rdata;
                        if (r_rdata > r_res.max_v) r_res.max_v <= r_rdata;
                    end else begin
                        r_pstep <= 1'b0;
                    end
                    if (r_pstep) r_sumsq <= r_sumsq + SQ_W'(r_prod);
                    if (r_left == '0 && !r_rvalid && !r_pstep)
                        r_state <= (r_res.count == '0) ? S_OUT : S_DIVM;
                end
                S_DIVM: begin
                    if (w_ddone) begin
                        r_res.mean <= w_quot[SAMPLE_BITS-1:0];
                        r_prod     <= (2*SUM_W)'(r_sum) * (2*SUM_W)'(r_sum);
                        r_pstep    <= 1'b0;
                        r_state    <= S_SQ;
                    end
                end
                S_SQ: begin
                    // first step forms n*sumsq - sum^2, second step starts divide
                    if (!r_pstep) begin
                        r_prod  <= (2*SUM_W)'(r_sumsq) * (2*SUM_W)'(r_res.count) - r_prod;
                        r_pstep <= 1'b1;
                    end else begin
                        r_pstep <= 1'b0;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (w_ddone) begin
                        r_res.var_v <= w_quot[VAR_W-1:0];
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_cnt_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(MAX_WINDOW)) else $error("period count overflow");
    a_cnt_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[1] <= CNT_W'(MAX_WINDOW)) else $error("duration count overflow");
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> r_state == S_IDLE) else $error("request while busy");
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_res.count != '0 |-> r_res.min_v <= r_res.max_v)
        else $error("min above max");
`endif

endmodule

// ===== src/loop_timing_window_stats.sv =====
// loop_timing_window_stats: top level with stream ports, config register and output stage
// depends on ltws_pkg and ltws_seq
`timescale 1ns / 1ps

// Loop timing statistics over sliding windows of periods (start to start) and
// durations (start to stop). One request is taken at a time: the ring is
// addressed, the window is walked one entry per cycle, then mean and variance
// are each found by a 63-step serial divide on one shared divider, with the
// S_SQ state between them forming the variance numerator. A clear walks an
// empty window and skips both divides. The result waits in an output register
// and the next request is taken only once that result has been taken. Command
// 3 is accepted and gives no result.

module loop_timing_window_stats
    import ltws_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // cmd[1:0], now_time[33:2], zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // sample_count, last, mean, variance, min, max
    output logic         m_axis_tuser    // series
);

    logic [6:0] r_win;
    logic [6:0] w_win;
    logic       r_ovalid;
    t_result    r_out, w_res;
    logic       w_busy, w_done, w_go;

    assign s_axis_tready = !w_busy && !r_ovalid;
    assign w_go = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != 2'd3;

    // trimming on a write uses the value being written
    assign w_win = i_cfg_we ? i_cfg_wdata : r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= 7'd64;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_win <= i_cfg_wdata;
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_out    <= w_res;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    ltws_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_cmd    (s_axis_tdata[1:0]),
        .i_now    (s_axis_tdata[33:2]),
        .i_win    (w_win),
        .i_cfg_we (i_cfg_we),
        .o_busy   (w_busy),
        .o_done   (w_done),
        .o_res    (w_res)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.series;
    assign m_axis_tdata  = {1'b0, r_out.max_v, r_out.min_v, r_out.var_v,
                            r_out.mean, r_out.last, r_out.count};

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for loop_timing_window_stats, stream requests in, stats out
// depends on ltws_pkg and the loop_timing_window_stats rtl
`timescale 1ns / 1ps

module tb;
    import ltws_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [6:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;   // cmd[1:0], now_time[33:2], zero fill
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;   // count, last, mean, variance, min, max
    logic         m_axis_tuser;   // series

    loop_timing_window_stats DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // timing predictor state
    logic [6:0]             window_reg;
    logic [31:0]            ref_time;
    logic [SAMPLE_BITS-1:0] period_ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] duration_ring [MAX_WINDOW];
    int                     period_head, duration_head, period_cnt, duration_cnt;

    t_result stats_queue[$];
    int      mismatches;
    bit      quiet;
    int      idle_cycles;

    function automatic int active_window();
        if (window_reg == 0) return 1;
        if (window_reg > MAX_WINDOW) return MAX_WINDOW;
        return window_reg;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] tick_delta(logic [31:0] now);
        logic [31:0] d;
        d = now - ref_time;
        return (d > SAMPLE_MAX) ? SAMPLE_MAX : d[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_result window_stats(logic which, logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW],
                                             int head, int n);
        t_result      r;
        bit [127:0]   sum, sumsq, x, mn, mx;
        int           first;
        r = '0;
        r.series = which;
        r.count = CNT_W'(n);
        if (n != 0) begin
            sum = 0;
            sumsq = 0;
            mn = 128'(SAMPLE_MAX);
            mx = 0;
            first = (head + MAX_WINDOW - n) % MAX_WINDOW;
            for (int i = 0; i < n; i++) begin
                x = 128'(ring[(first + i) % MAX_WINDOW]);
                sum += x;
                sumsq += x * x;
                if (x < mn) mn = x;
                if (x > mx) mx = x;
                r.last = x[SAMPLE_BITS-1:0];
            end
            r.mean = SAMPLE_BITS'(sum / 128'(n));
            r.var_v = VAR_W'((128'(n) * sumsq - sum * sum) / (128'(n) * 128'(n)));
            r.min_v = mn[SAMPLE_BITS-1:0];
            r.max_v = mx[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    // advances the predictor by one event, returns 0 when no result follows
    function automatic bit predict_event(logic [1:0] cmd, logic [31:0] now, output t_result r);
        logic [SAMPLE_BITS-1:0] d;
        d = tick_delta(now);
        case (cmd)
            CMD_START: begin
                ref_time = now;
                period_ring[period_head] = d;
                period_head = (period_head + 1) % MAX_WINDOW;
                if (period_cnt < MAX_WINDOW) period_cnt++;
                if (period_cnt > active_window()) period_cnt = active_window();
                r = window_stats(1'b0, period_ring, period_head, period_cnt);
                return 1;
            end
            CMD_STOP: begin
                duration_ring[duration_head] = d;
                duration_head = (duration_head + 1) % MAX_WINDOW;
                if (duration_cnt < MAX_WINDOW) duration_cnt++;
                if (duration_cnt > active_window()) duration_cnt = active_window();
                r = window_stats(1'b1, duration_ring, duration_head, duration_cnt);
                return 1;
            end
            CMD_CLEAR: begin
                period_cnt = 0;
                duration_cnt = 0;
                r = '0;
                return 1;
            end
            default: begin
                r = '0;
                return 0;
            end
        endcase
    endfunction

    task automatic send_event(logic [1:0] cmd, logic [31:0] now, bit typed, t_result typed_r);
        t_result r;
        int      gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, now, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_event(cmd, now, r))
            stats_queue.insert(stats_queue.size(), typed ? typed_r : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (stats_queue.size() != 0) @(posedge i_clk);
        // command 3 gives no result, so let any walk finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [6:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        window_reg = v;
        if (period_cnt > active_window()) period_cnt = active_window();
        if (duration_cnt > active_window()) duration_cnt = active_window();
    endtask

    // output side: random stall bursts, then compare with the oldest expectation
    int stall_left;
    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.series = m_axis_tuser;
                got.count  = m_axis_tdata[6:0];
                got.last   = m_axis_tdata[30:7];
                got.mean   = m_axis_tdata[54:31];
                got.var_v  = m_axis_tdata[102:55];
                got.min_v  = m_axis_tdata[126:103];
                got.max_v  = m_axis_tdata[150:127];
                if (stats_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", got);
                end else begin
                    exp_r = stats_queue.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] now;
        bit          typed;
        t_result     r;
    } t_row;

    t_row        directed [12];
    logic [6:0]  window_plan [10] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd5, 7'd17, 7'd3,
                                      7'd64, 7'd40, 7'd2};
    logic [31:0] clock_now;
    logic [1:0]  cmd;
    int          n_items;

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        quiet         = 0;
        window_reg    = 7'd64;
        ref_time      = '0;
        period_head = 0; duration_head = 0; period_cnt = 0; duration_cnt = 0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            period_ring[i] = '0;
            duration_ring[i] = '0;
        end

        // clear on empty, zero deltas, saturation, wraparound, unused command
        directed[0]  = '{CMD_CLEAR, 32'h0, 1, '0};
        directed[1]  = '{CMD_START, 32'h0, 1, '{1'b0, 7'd1, 24'd0, 24'd0, 48'd0, 24'd0, 24'd0}};
        directed[2]  = '{CMD_STOP,  32'h0, 1, '{1'b1, 7'd1, 24'd0, 24'd0, 48'd0, 24'd0, 24'd0}};
        directed[3]  = '{CMD_START, 32'hFFFF_FFFF, 0, '0};
        directed[4]  = '{CMD_STOP,  32'h0000_0000, 0, '0};
        directed[5]  = '{2'd3,      32'hAAAA_5555, 0, '0};
        directed[6]  = '{CMD_STOP,  32'h00FF_FFFE, 0, '0};
        directed[7]  = '{CMD_START, 32'h00FF_FFFE, 0, '0};
        directed[8]  = '{CMD_STOP,  32'h55AA_0000, 0, '0};
        directed[9]  = '{CMD_START, 32'h55AA_0001, 0, '0};
        directed[10] = '{CMD_CLEAR, 32'h1234_5678, 1, '0};
        directed[11] = '{CMD_STOP,  32'h55AA_0010, 0, '0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_event(directed[i].cmd, directed[i].now, directed[i].typed, directed[i].r);

        clock_now = $urandom;
        foreach (window_plan[p]) begin
            write_window(window_plan[p]);
            if (p == 9) quiet = 1;
            n_items = 95;
            for (int k = 0; k < n_items; k++) begin
                // mostly start/stop pairs with small timings, some noise
                case ($urandom_range(0, 19))
                    0:       cmd = CMD_CLEAR;
                    1:       cmd = 2'd3;
                    2, 3:    cmd = 2'($urandom_range(0, 1));
                    default: cmd = (k % 2 == 0) ? CMD_START : CMD_STOP;
                endcase
                if ($urandom_range(0, 15) == 0) clock_now = $urandom;
                else if ($urandom_range(0, 15) == 0) clock_now += $urandom_range(0, 32'h0200_0000);
                else clock_now += $urandom_range(0, 3000);
                send_event(cmd, clock_now, 0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (stats_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
